[hdl/assert_macros.svh]
// Assertion macros used by the checker file lbsd_checker.sv.
// No dependencies; take in with `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define LBSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LBSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/lbsd_pkg.sv]
// Shared constants and types for the lidar basic-scan deframer.
// No dependencies; imported by the decoder and the top level.
package lbsd_pkg;

    localparam int RECORD_BYTES = 5;
    localparam int WINDOW_W     = 8 * RECORD_BYTES;
    localparam int PHASE_W      = $clog2(RECORD_BYTES);
    localparam int COUNT_W      = 4;

    localparam logic [COUNT_W-1:0] SYNC_RECORDS_RESET = 4'd4;
    localparam logic [COUNT_W-1:0] SYNC_COUNT_MAX     = 4'd15;

    // start bits of record byte zero
    localparam logic [1:0] START_SCAN   = 2'b01;
    localparam logic [1:0] START_NORMAL = 2'b10;

    typedef struct packed {
        logic is_start;
        logic is_normal;
    } rec_flags_t;

    typedef struct packed {
        logic [5:0]  quality;
        logic [14:0] angle_q6;
        logic [8:0]  angle_bin;
        logic [13:0] distance;
        logic        scan_start;
        logic        keep;
        logic        check_error;
    } sample_t;

endpackage

[hdl/lbsd_record_decode.sv]
// Record decoder: classifies the five-byte window and unpacks its sample fields.
// Depends on lbsd_pkg.
module lbsd_record_decode (
    input  logic [lbsd_pkg::WINDOW_W-1:0] window,
    output lbsd_pkg::rec_flags_t          flags,
    output lbsd_pkg::sample_t             sample
);
    import lbsd_pkg::*;

    logic [7:0] b0, b1, b2, b3, b4;
    logic [1:0] sb;
    logic [15:0] dist_raw;

    // oldest byte sits at the top of the window
    assign b0 = window[39:32];
    assign b1 = window[31:24];
    assign b2 = window[23:16];
    assign b3 = window[15:8];
    assign b4 = window[7:0];
    assign sb = b0[1:0];
    assign dist_raw = {b4, b3};

    assign flags.is_start  = (sb == START_SCAN)   && b1[0];
    assign flags.is_normal = (sb == START_NORMAL) && b1[0];

    assign sample.quality     = b0[7:2];
    assign sample.angle_q6    = {b2[7:0], b1[7:1]};
    assign sample.angle_bin   = {b2[7:0], b1[7]};
    assign sample.distance    = dist_raw[15:2];
    assign sample.scan_start  = (sb == START_SCAN);
    assign sample.keep        = (b0[7:2] != 6'd0);
    assign sample.check_error = !((sb == START_SCAN) || (sb == START_NORMAL)) || !b1[0];

endmodule

[hdl/lidar_basic_scan_deframer.sv]
// Top level of the lidar basic-scan deframer: sync state and output register.
// Depends on lbsd_pkg and lbsd_record_decode.
//
// Takes one serial byte per clock on the s_ channel, while s_ready is high, and
// hunts for a start-of-scan record, then needs cfg_wr_data normal records in a row
// before it locks. Once locked, every fifth byte yields one sample on the m_ channel
// in the cycle after that byte is taken; sync records give no sample. s_ready is
// low only while a sample sits in the single output register and m_ready is low, so
// the block sustains one byte per cycle with m_ready high. Lock holds until reset.
module lidar_basic_scan_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_quality,
    output logic [14:0] m_angle_q6,
    output logic [8:0]  m_angle_bin,
    output logic [13:0] m_distance,
    output logic        m_scan_start,
    output logic        m_keep,
    output logic        m_check_error
);
    import lbsd_pkg::*;

    logic [WINDOW_W-1:0] window_reg, window_next, window_shift;
    logic [PHASE_W-1:0]  phase_reg, phase_next, phase_inc;
    logic                locked_reg, locked_next;
    logic                aligned_reg, aligned_next;
    logic [COUNT_W-1:0]  count_reg, count_next, count_inc;
    logic [COUNT_W-1:0]  sync_records_reg;
    logic                m_valid_reg, m_valid_next;
    sample_t             sample_reg, sample_next;
    rec_flags_t          flags;
    sample_t             sample;
    logic                accept;
    logic                emit;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign window_shift = {window_reg[WINDOW_W-9:0], s_rx_byte};
    assign phase_inc    = phase_reg + PHASE_W'(1);
    assign count_inc    = (count_reg == SYNC_COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    lbsd_record_decode u_decode (
        .window (window_shift),
        .flags  (flags),
        .sample (sample)
    );

    always_comb begin
        window_next  = window_reg;
        phase_next   = phase_reg;
        locked_next  = locked_reg;
        aligned_next = aligned_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        if (accept) begin
            window_next = window_shift;
            if (!locked_reg && !aligned_reg) begin
                if (flags.is_start) begin
                    phase_next = '0;
                    count_next = '0;
                    if (sync_records_reg == '0) begin
                        locked_next = 1'b1;
                    end else begin
                        aligned_next = 1'b1;
                    end
                end
            end else if (phase_inc < PHASE_W'(RECORD_BYTES)) begin
                phase_next = phase_inc;
            end else begin
                phase_next = '0;
                if (!locked_reg) begin
                    if (flags.is_normal) begin
                        count_next = count_inc;
                        if (count_inc >= sync_records_reg) begin
                            locked_next  = 1'b1;
                            aligned_next = 1'b0;
                        end
                    end else if (flags.is_start) begin
                        // realign on this start record
                        count_next = '0;
                        if (sync_records_reg == '0) begin
                            locked_next  = 1'b1;
                            aligned_next = 1'b0;
                        end else begin
                            aligned_next = 1'b1;
                        end
                    end else begin
                        aligned_next = 1'b0;
                        count_next   = '0;
                    end
                end else begin
                    emit = 1'b1;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        sample_next  = sample_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            sample_next  = sample;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg       <= '0;
            phase_reg        <= '0;
            locked_reg       <= 1'b0;
            aligned_reg      <= 1'b0;
            count_reg        <= '0;
            sync_records_reg <= SYNC_RECORDS_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            window_reg  <= window_next;
            phase_reg   <= phase_next;
            locked_reg  <= locked_next;
            aligned_reg <= aligned_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                sync_records_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_quality     = sample_reg.quality;
    assign m_angle_q6    = sample_reg.angle_q6;
    assign m_angle_bin   = sample_reg.angle_bin;
    assign m_distance    = sample_reg.distance;
    assign m_scan_start  = sample_reg.scan_start;
    assign m_keep        = sample_reg.keep;
    assign m_check_error = sample_reg.check_error;

endmodule

[hdl/lbsd_checker.sv]
// Port-level checker for the lidar basic-scan deframer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lbsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_quality,
    input logic [14:0] m_angle_q6,
    input logic [8:0]  m_angle_bin,
    input logic        m_keep
);

    `LBSD_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "m_valid after reset")

    `LBSD_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_angle_q6) && $stable(m_quality), "stalled word changed")

    `LBSD_ASSERT(a_stall_back, aclk, aresetn, m_valid && !m_ready |-> !s_ready, "input taken while output full")

    `LBSD_ASSERT(a_bin_match, aclk, aresetn, m_valid |-> (m_angle_bin == m_angle_q6[14:6]), "angle bin mismatch")

    `LBSD_ASSERT(a_keep_match, aclk, aresetn, m_valid |-> (m_keep == (m_quality != 6'd0)), "keep flag mismatch")

endmodule

bind lidar_basic_scan_deframer lbsd_checker u_lbsd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_quality   (m_quality),
    .m_angle_q6  (m_angle_q6),
    .m_angle_bin (m_angle_bin),
    .m_keep      (m_keep)
);
